@@ sv/assert_macros.svh @@
// Assertion macros shared by the console writer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication does not hold");

// Check that a condition is never true.
`define ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: forbidden condition seen");

`endif

@@ sv/tccw_pkg.sv @@
// Package with types and constants of the text console character writer.
`timescale 1ns / 1ps

package tccw_pkg;

    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 25;

    localparam int COL_W      = 7;
    localparam int ROW_W      = 6;
    localparam int OFFS_W     = 13;
    localparam int IDX_W      = 11;
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int OUT_ROW_W  = 5;
    localparam int OUT_OFFS_W = 11;
    localparam int COLOR_W    = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CELL_W     = CHAR_W + ATTR_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int TAB_STEP   = 8;

    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 1'b1;

    localparam logic [COLOR_W-1:0] BACKGROUND_RESET = 4'd0;
    localparam logic [COLOR_W-1:0] FOREGROUND_RESET = 4'd7;

    localparam logic [CHAR_W-1:0] CHAR_BS       = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_TAB      = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_LF       = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR       = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE    = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_PRINT_HI = 8'h7F;

    typedef enum logic [1:0] {
        ACT_PUT   = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_SET   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        CLS_BS,
        CLS_TAB,
        CLS_CR,
        CLS_LF,
        CLS_PRINT,
        CLS_IGNORE
    } char_class_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_CLEAR,
        BK_SCROLL,
        BK_SCROLL_END
    } back_state_t;

    typedef struct packed {
        action_t             act;
        char_class_t         cls;
        logic [CHAR_W-1:0]   ch;
        logic                idx_ok;
        logic [IDX_W-1:0]    idx;
        logic [COL_W-1:0]    col;
        logic [ROW_W-1:0]    row;
    } cmd_t;

    typedef struct packed {
        logic [COL_W-1:0]      col;
        logic [OUT_ROW_W-1:0]  row;
        logic [OUT_OFFS_W-1:0] offset;
        logic [CHAR_W-1:0]     ch;
        logic [ATTR_W-1:0]     attr;
    } res_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

@@ sv/tccw_front.sv @@
// Front end: accept transactions and classify them into commands.
`timescale 1ns / 1ps

module tccw_front #(
    parameter int COLUMNS = tccw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tccw_pkg::ROWS_DEFAULT
) (
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     action,
    input  logic [tccw_pkg::CHAR_W-1:0]    char_code,
    input  logic [tccw_pkg::IDX_W-1:0]     cell_index,
    input  logic [tccw_pkg::COL_W-1:0]     new_column,
    input  logic [tccw_pkg::OUT_ROW_W-1:0] new_row,
    input  tccw_pkg::q_stat_t              q_stat,
    output logic                           push,
    output tccw_pkg::cmd_t                 cmd
);

    localparam int CELLS = COLUMNS * ROWS;

    assign in_ready = !q_stat.full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        cmd.act = tccw_pkg::action_t'(action);
        cmd.ch  = char_code;
        cmd.idx = cell_index;

        if (char_code >= tccw_pkg::CHAR_SPACE && char_code <= tccw_pkg::CHAR_PRINT_HI)
        begin
            cmd.cls = tccw_pkg::CLS_PRINT;
        end
        else
        begin
            unique case (char_code)
                tccw_pkg::CHAR_BS:  cmd.cls = tccw_pkg::CLS_BS;
                tccw_pkg::CHAR_TAB: cmd.cls = tccw_pkg::CLS_TAB;
                tccw_pkg::CHAR_CR:  cmd.cls = tccw_pkg::CLS_CR;
                tccw_pkg::CHAR_LF:  cmd.cls = tccw_pkg::CLS_LF;
                default:            cmd.cls = tccw_pkg::CLS_IGNORE;
            endcase
        end

        // Saturate the requested cursor to the screen.
        if (8'(new_column) >= 8'(COLUMNS))
            cmd.col = tccw_pkg::COL_W'(COLUMNS - 1);
        else
            cmd.col = new_column;

        if (7'(new_row) >= 7'(ROWS))
            cmd.row = tccw_pkg::ROW_W'(ROWS - 1);
        else
            cmd.row = tccw_pkg::ROW_W'(new_row);

        cmd.idx_ok = (14'(cell_index) < 14'(CELLS));
    end

endmodule

@@ sv/tccw_queue.sv @@
// Short command queue between the front and back ends.
`timescale 1ns / 1ps

module tccw_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tccw_pkg::cmd_t    push_data,
    input  logic              pop,
    output logic              head_valid,
    output tccw_pkg::cmd_t    head_data,
    output tccw_pkg::q_stat_t stat
);

    localparam int DEPTH = tccw_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tccw_pkg::cmd_t   entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head_valid = !stat.empty;
    assign head_data  = entries_reg[rd_ptr_reg];

    assign do_push = push && !stat.full;
    assign do_pop  = pop && !stat.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_data;
    end

endmodule

@@ sv/tccw_back.sv @@
// Back end: cursor, screen memory, clear and scroll sweeps, result register.
`timescale 1ns / 1ps

module tccw_back #(
    parameter int COLUMNS = tccw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tccw_pkg::ROWS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    input  tccw_pkg::cmd_t              cmd,
    output logic                        cmd_pop,
    input  logic [tccw_pkg::ATTR_W-1:0] attr,
    output logic                        res_valid,
    input  logic                        res_ready,
    output tccw_pkg::res_t              res
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = tccw_pkg::COL_W;
    localparam int ROW_W  = tccw_pkg::ROW_W;
    localparam int OFFS_W = tccw_pkg::OFFS_W;
    localparam int CELL_W = tccw_pkg::CELL_W;

    tccw_pkg::back_state_t state_reg, state_next;

    logic [CELL_W-1:0] screen_mem [CELLS];
    logic [CELL_W-1:0] rd_data_reg;

    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic              pipe_vld_reg, pipe_vld_next;
    logic [ADDR_W-1:0] pipe_addr_reg, pipe_addr_next;
    logic              res_vld_reg, res_vld_next;
    tccw_pkg::res_t    res_reg, res_next;

    logic              start;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_wa, mem_ra;
    logic [CELL_W-1:0] mem_wd;
    logic              res_load;
    logic [tccw_pkg::CHAR_W-1:0] res_ch;
    logic [tccw_pkg::ATTR_W-1:0] res_attr;

    logic [COL_W:0]    col_w;
    logic [ROW_W:0]    row_w;
    logic [COL_W-1:0]  put_col;
    logic [ROW_W-1:0]  put_row;
    logic              put_we, put_scroll;
    logic [OFFS_W-1:0] cur_pos, res_pos;
    logic [ADDR_W-1:0] rd_idx;
    logic              clear_last, scroll_last;

    assign start   = (state_reg == tccw_pkg::BK_IDLE) && cmd_valid
                     && (!res_vld_reg || res_ready);
    assign cmd_pop = start;

    assign cur_pos = OFFS_W'(cur_row_reg) * OFFS_W'(COLUMNS) + OFFS_W'(cur_col_reg);
    assign rd_idx  = ADDR_W'(OFFS_W'(cmd.idx));

    assign clear_last  = (cnt_reg == ADDR_W'(CELLS - 1));
    assign scroll_last = (cnt_reg == ADDR_W'(CELLS - 1));

    // Cursor motion for a put, including wrap and scroll detection.
    always_comb
    begin
        col_w  = {1'b0, cur_col_reg};
        row_w  = {1'b0, cur_row_reg};
        put_we = 1'b0;
        unique case (cmd.cls)
            tccw_pkg::CLS_BS:
            begin
                if (cur_col_reg != '0)
                    col_w = col_w - 1'b1;
                else if (cur_row_reg != '0)
                begin
                    col_w = (COL_W + 1)'(COLUMNS - 1);
                    row_w = row_w - 1'b1;
                end
            end
            tccw_pkg::CLS_TAB:
                col_w = (col_w + (COL_W + 1)'(tccw_pkg::TAB_STEP))
                        & ~(COL_W + 1)'(tccw_pkg::TAB_STEP - 1);
            tccw_pkg::CLS_CR:
                col_w = '0;
            tccw_pkg::CLS_LF:
                row_w = row_w + 1'b1;
            tccw_pkg::CLS_PRINT:
            begin
                put_we = 1'b1;
                col_w  = col_w + 1'b1;
            end
            default:
            begin
            end
        endcase

        if (col_w >= (COL_W + 1)'(COLUMNS))
        begin
            col_w = '0;
            row_w = row_w + 1'b1;
        end

        put_scroll = (row_w >= (ROW_W + 1)'(ROWS));
        if (put_scroll)
            row_w = (ROW_W + 1)'(ROWS - 1);

        put_col = col_w[COL_W-1:0];
        put_row = row_w[ROW_W-1:0];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tccw_pkg::BK_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd.act)
                        tccw_pkg::ACT_PUT:
                            if (put_scroll)
                                state_next = tccw_pkg::BK_SCROLL;
                        tccw_pkg::ACT_READ:
                            if (cmd.idx_ok)
                                state_next = tccw_pkg::BK_READ;
                        tccw_pkg::ACT_CLEAR:
                            state_next = tccw_pkg::BK_CLEAR;
                        default:
                            state_next = tccw_pkg::BK_IDLE;
                    endcase
                end
            end
            tccw_pkg::BK_READ:
                state_next = tccw_pkg::BK_IDLE;
            tccw_pkg::BK_CLEAR:
                if (clear_last)
                    state_next = tccw_pkg::BK_IDLE;
            tccw_pkg::BK_SCROLL:
                if (scroll_last)
                    state_next = tccw_pkg::BK_SCROLL_END;
            tccw_pkg::BK_SCROLL_END:
                state_next = tccw_pkg::BK_IDLE;
            default:
                state_next = tccw_pkg::BK_IDLE;
        endcase
    end

    // Datapath controls.
    always_comb
    begin
        mem_we         = 1'b0;
        mem_wa         = cnt_reg;
        mem_wd         = {attr, tccw_pkg::CHAR_SPACE};
        mem_re         = 1'b0;
        mem_ra         = cnt_reg;
        cnt_next       = cnt_reg;
        pipe_vld_next  = 1'b0;
        pipe_addr_next = pipe_addr_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        res_load       = 1'b0;
        res_ch         = '0;
        res_attr       = '0;

        unique case (state_reg)
            tccw_pkg::BK_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd.act)
                        tccw_pkg::ACT_PUT:
                        begin
                            cur_col_next = put_col;
                            cur_row_next = put_row;
                            mem_we       = put_we;
                            mem_wa       = ADDR_W'(cur_pos);
                            mem_wd       = {attr, cmd.ch};
                            if (put_scroll)
                                cnt_next = ADDR_W'(COLUMNS);
                            else
                                res_load = 1'b1;
                        end
                        tccw_pkg::ACT_READ:
                        begin
                            mem_re = cmd.idx_ok;
                            mem_ra = rd_idx;
                            res_load = !cmd.idx_ok;
                        end
                        tccw_pkg::ACT_CLEAR:
                            cnt_next = '0;
                        default:
                        begin
                            cur_col_next = cmd.col;
                            cur_row_next = cmd.row;
                            res_load     = 1'b1;
                        end
                    endcase
                end
            end
            tccw_pkg::BK_READ:
            begin
                res_load = 1'b1;
                res_ch   = rd_data_reg[tccw_pkg::CHAR_W-1:0];
                res_attr = rd_data_reg[CELL_W-1:tccw_pkg::CHAR_W];
            end
            tccw_pkg::BK_CLEAR:
            begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                res_load = clear_last;
            end
            tccw_pkg::BK_SCROLL:
            begin
                // Read one row below, write it back in the following cycle.
                mem_re         = 1'b1;
                pipe_vld_next  = 1'b1;
                pipe_addr_next = cnt_reg - ADDR_W'(COLUMNS);
                cnt_next       = cnt_reg + 1'b1;
                mem_we         = pipe_vld_reg;
                mem_wa         = pipe_addr_reg;
                mem_wd         = rd_data_reg;
            end
            tccw_pkg::BK_SCROLL_END:
            begin
                mem_we   = pipe_vld_reg;
                mem_wa   = pipe_addr_reg;
                mem_wd   = rd_data_reg;
                res_load = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Result built from the cursor as it stands after this step.
    always_comb
    begin
        res_pos         = OFFS_W'(cur_row_next) * OFFS_W'(COLUMNS) + OFFS_W'(cur_col_next);
        res_next.col    = cur_col_next;
        res_next.row    = cur_row_next[tccw_pkg::OUT_ROW_W-1:0];
        res_next.offset = res_pos[tccw_pkg::OUT_OFFS_W-1:0];
        res_next.ch     = res_ch;
        res_next.attr   = res_attr;

        if (res_load)
            res_vld_next = 1'b1;
        else if (res_ready)
            res_vld_next = 1'b0;
        else
            res_vld_next = res_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tccw_pkg::BK_IDLE;
            cur_col_reg  <= '0;
            cur_row_reg  <= '0;
            cnt_reg      <= '0;
            pipe_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_col_reg  <= cur_col_next;
            cur_row_reg  <= cur_row_next;
            cnt_reg      <= cnt_next;
            pipe_vld_reg <= pipe_vld_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_addr_reg <= pipe_addr_next;
        if (res_load)
            res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            screen_mem[mem_wa] <= mem_wd;
        if (mem_re)
            rd_data_reg <= screen_mem[mem_ra];
    end

    assign res_valid = res_vld_reg;
    assign res       = res_reg;

endmodule

@@ sv/text_console_character_writer.sv @@
// Top level of the text console character writer.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Text console engine over a COLUMNS x ROWS screen of 16-bit cells (character
// in the low byte, attribute {background, foreground} in the high byte). Each
// input transaction puts a character (backspace, tab, carriage return, line
// feed, printable 0x20..0x7F; other bytes only report the cursor), reads a
// cell, clears the screen or sets the cursor, and returns exactly one output
// transaction with the cursor, its linear offset and, for a read, the cell.
// The front end takes transactions into a two-entry command queue, so input is
// accepted while the back end works or an output transaction waits. The back
// end runs one command at a time against a single-port-per-direction screen
// memory: a put, a set cursor or an out-of-range read reports straight from
// the idle state, a read passes through BK_READ, a clear writes every cell in
// turn, and a put that moves past the last row scrolls with one cell copied
// per cycle, then finishes in BK_SCROLL_END. The screen has no reset; read a
// cell only after it was written. Write background_color (index 0) and
// foreground_color (index 1) only while the block is idle.

module text_console_character_writer #(
    parameter int COLUMNS = tccw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tccw_pkg::ROWS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,

    // Configuration writes
    input  logic                            cfg_write,
    input  logic [tccw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tccw_pkg::COLOR_W-1:0]    cfg_data,

    // Input transactions
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      action,
    input  logic [tccw_pkg::CHAR_W-1:0]     char_code,
    input  logic [tccw_pkg::IDX_W-1:0]      cell_index,
    input  logic [tccw_pkg::COL_W-1:0]      new_column,
    input  logic [tccw_pkg::OUT_ROW_W-1:0]  new_row,

    // Output transactions
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tccw_pkg::COL_W-1:0]      cursor_column,
    output logic [tccw_pkg::OUT_ROW_W-1:0]  cursor_row,
    output logic [tccw_pkg::OUT_OFFS_W-1:0] cursor_offset,
    output logic [tccw_pkg::CHAR_W-1:0]     cell_char,
    output logic [tccw_pkg::ATTR_W-1:0]     cell_attr
);

    logic [tccw_pkg::COLOR_W-1:0] bg_reg, bg_next;
    logic [tccw_pkg::COLOR_W-1:0] fg_reg, fg_next;

    tccw_pkg::q_stat_t q_stat;
    tccw_pkg::cmd_t    front_cmd;
    tccw_pkg::cmd_t    head_cmd;
    tccw_pkg::res_t    res;
    logic              push;
    logic              head_valid;
    logic              pop;

    // Color registers; indexes without a register are dropped.
    always_comb
    begin
        bg_next = bg_reg;
        fg_next = fg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                tccw_pkg::REG_BACKGROUND: bg_next = cfg_data;
                tccw_pkg::REG_FOREGROUND: fg_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bg_reg <= tccw_pkg::BACKGROUND_RESET;
            fg_reg <= tccw_pkg::FOREGROUND_RESET;
        end
        else
        begin
            bg_reg <= bg_next;
            fg_reg <= fg_next;
        end
    end

    // Accept and classify.
    tccw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .char_code  (char_code),
        .cell_index (cell_index),
        .new_column (new_column),
        .new_row    (new_row),
        .q_stat     (q_stat),
        .push       (push),
        .cmd        (front_cmd)
    );

    // Hold commands until the back end is free.
    tccw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (front_cmd),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_cmd),
        .stat       (q_stat)
    );

    // Execute against the cursor and the screen memory.
    tccw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (head_valid),
        .cmd       (head_cmd),
        .cmd_pop   (pop),
        .attr      ({bg_reg, fg_reg}),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res       (res)
    );

    assign cursor_column = res.col;
    assign cursor_row    = res.row;
    assign cursor_offset = res.offset;
    assign cell_char     = res.ch;
    assign cell_attr     = res.attr;

    // A reported cursor column always lies on the screen.
    `ASSERT_IMPLIES(a_column_on_screen, out_valid, 8'(cursor_column) < 8'(COLUMNS))
    // A full queue must stall the input side.
    `ASSERT_IMPLIES(a_full_stalls_input, q_stat.full, !in_ready)
    // The queue can never be full and empty at once.
    `ASSERT_NEVER(a_queue_count_sane, q_stat.full && q_stat.empty)

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the text console character writer.
`timescale 1ns / 1ps

module testbench;

    // Screen geometry of the instance under test.
    localparam int COLS  = tccw_pkg::COLUMNS_DEFAULT;
    localparam int LINES = tccw_pkg::ROWS_DEFAULT;
    localparam int CELLS = COLS * LINES;

    // Cycles without any transaction before the run is declared hung. The
    // slowest legal stretch is a scroll plus a clear queued behind it,
    // or the settle pause between phases.
    localparam int HANG_LIMIT = 20000;

    // Cycles to let a scroll or clear run out after the last report.
    localparam int SETTLE_CYCLES = 2100;

    // One console command as presented on the input channel.
    typedef struct packed {
        tccw_pkg::action_t                act;
        logic [tccw_pkg::CHAR_W-1:0]      ch;
        logic [tccw_pkg::IDX_W-1:0]       idx;
        logic [tccw_pkg::COL_W-1:0]       col;
        logic [tccw_pkg::OUT_ROW_W-1:0]   row;
    } console_cmd_t;

    // A command waiting to be sent, with the cursor report it must produce.
    typedef struct {
        console_cmd_t   cmd;
        tccw_pkg::res_t report;
    } console_job_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                              cfg_write = 1'b0;
    logic [tccw_pkg::CFG_IDX_W-1:0]    cfg_index = tccw_pkg::REG_BACKGROUND;
    logic [tccw_pkg::COLOR_W-1:0]      cfg_data  = '0;

    logic                              in_valid   = 1'b0;
    logic                              in_ready;
    logic [1:0]                        action     = tccw_pkg::ACT_PUT;
    logic [tccw_pkg::CHAR_W-1:0]       char_code  = '0;
    logic [tccw_pkg::IDX_W-1:0]        cell_index = '0;
    logic [tccw_pkg::COL_W-1:0]        new_column = '0;
    logic [tccw_pkg::OUT_ROW_W-1:0]    new_row    = '0;

    logic                              out_valid;
    logic                              out_ready  = 1'b0;
    logic [tccw_pkg::COL_W-1:0]        cursor_column;
    logic [tccw_pkg::OUT_ROW_W-1:0]    cursor_row;
    logic [tccw_pkg::OUT_OFFS_W-1:0]   cursor_offset;
    logic [tccw_pkg::CHAR_W-1:0]       cell_char;
    logic [tccw_pkg::ATTR_W-1:0]       cell_attr;

    // Commands produced by the stimulus, in send order.
    console_job_t    jobs_pending[$];
    // Cursor reports owed by the block for accepted commands, oldest first.
    tccw_pkg::res_t  reports_due[$];
    tccw_pkg::res_t  held_report;

    // Shadow console: screen, which cells hold known data, cursor, colors.
    logic [tccw_pkg::CELL_W-1:0]  screen_shadow [CELLS];
    bit                           cell_known    [CELLS];
    int                           shadow_col;
    int                           shadow_row;
    logic [tccw_pkg::COLOR_W-1:0] shadow_bg;
    logic [tccw_pkg::COLOR_W-1:0] shadow_fg;

    bit  idle_enable = 1'b1;
    int  send_gap;
    int  stall_left;
    int  quiet_cycles;
    int  fail_count;
    int  cmds_sent;
    int  reports_seen;
    int  scroll_count;
    int  clear_count;
    int  clears_left;
    int  reads_of_cells;

    text_console_character_writer #(
        .COLUMNS (COLS),
        .ROWS    (LINES)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .char_code     (char_code),
        .cell_index    (cell_index),
        .new_column    (new_column),
        .new_row       (new_row),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cursor_column (cursor_column),
        .cursor_row    (cursor_row),
        .cursor_offset (cursor_offset),
        .cell_char     (cell_char),
        .cell_attr     (cell_attr)
    );

    always #5 clk = ~clk;

    // Mostly short gaps, now and then a long one; none while idling is off.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_enable || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Apply one command to the shadow console and return the report it yields.
    task automatic advance_console(input console_cmd_t c, output tccw_pkg::res_t rep);
        int pos;
        rep = '0;
        case (c.act)
            tccw_pkg::ACT_PUT:
            begin
                if (c.ch == tccw_pkg::CHAR_BS)
                begin
                    // Step back; at column 0 wrap to the end of the previous row,
                    // and stay put at the origin.
                    if (shadow_col != 0)
                    begin
                        shadow_col--;
                    end
                    else if (shadow_row != 0)
                    begin
                        shadow_col = COLS - 1;
                        shadow_row--;
                    end
                end
                else if (c.ch == tccw_pkg::CHAR_TAB)
                begin
                    shadow_col = (shadow_col + tccw_pkg::TAB_STEP)
                                 & ~(tccw_pkg::TAB_STEP - 1);
                end
                else if (c.ch == tccw_pkg::CHAR_CR)
                begin
                    shadow_col = 0;
                end
                else if (c.ch == tccw_pkg::CHAR_LF)
                begin
                    shadow_row++;
                end
                else if (c.ch >= tccw_pkg::CHAR_SPACE && c.ch <= tccw_pkg::CHAR_PRINT_HI)
                begin
                    pos = shadow_row * COLS + shadow_col;
                    screen_shadow[pos] = {shadow_bg, shadow_fg, c.ch};
                    cell_known[pos]    = 1'b1;
                    shadow_col++;
                end
                if (shadow_col >= COLS)
                begin
                    shadow_col = 0;
                    shadow_row++;
                end
                if (shadow_row >= LINES)
                begin
                    // Scroll up one row; the bottom row keeps what it held.
                    shadow_row = LINES - 1;
                    for (int i = 0; i < CELLS - COLS; i++)
                    begin
                        screen_shadow[i] = screen_shadow[i + COLS];
                        cell_known[i]    = cell_known[i + COLS];
                    end
                    scroll_count++;
                end
            end
            tccw_pkg::ACT_READ:
            begin
                if (c.idx < CELLS)
                begin
                    rep.ch   = screen_shadow[c.idx][tccw_pkg::CHAR_W-1:0];
                    rep.attr = screen_shadow[c.idx][tccw_pkg::CELL_W-1:tccw_pkg::CHAR_W];
                    reads_of_cells++;
                end
            end
            tccw_pkg::ACT_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                begin
                    screen_shadow[i] = {shadow_bg, shadow_fg, tccw_pkg::CHAR_SPACE};
                    cell_known[i]    = 1'b1;
                end
                clear_count++;
            end
            default:
            begin
                // Set cursor saturates each coordinate at the screen edge.
                shadow_col = (c.col >= COLS) ? COLS - 1 : int'(c.col);
                shadow_row = (c.row >= LINES) ? LINES - 1 : int'(c.row);
            end
        endcase
        rep.col    = tccw_pkg::COL_W'(shadow_col);
        rep.row    = tccw_pkg::OUT_ROW_W'(shadow_row);
        rep.offset = tccw_pkg::OUT_OFFS_W'(shadow_row * COLS + shadow_col);
    endtask

    // Predict a command and append it to the send queue.
    task automatic queue_cmd(input tccw_pkg::action_t act,
                             input logic [tccw_pkg::CHAR_W-1:0] ch,
                             input logic [tccw_pkg::IDX_W-1:0] idx,
                             input logic [tccw_pkg::COL_W-1:0] col,
                             input logic [tccw_pkg::OUT_ROW_W-1:0] row);
        console_job_t j;
        j.cmd.act = act;
        j.cmd.ch  = ch;
        j.cmd.idx = idx;
        j.cmd.col = col;
        j.cmd.row = row;
        advance_console(j.cmd, j.report);
        jobs_pending.push_back(j);
    endtask

    // Build one random command. Reads only target cells that hold known data,
    // or lie beyond the screen.
    task automatic queue_random_cmd();
        int           pick;
        int           cand;
        int           pos;
        console_cmd_t c;
        c.act = tccw_pkg::ACT_PUT;
        c.ch  = tccw_pkg::CHAR_W'($urandom_range(0, 255));
        c.idx = tccw_pkg::IDX_W'($urandom_range(0, 2047));
        c.col = tccw_pkg::COL_W'($urandom_range(0, 127));
        c.row = tccw_pkg::OUT_ROW_W'($urandom_range(0, 31));
        pick  = $urandom_range(0, 99);
        if (pick < 60)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                c.ch = tccw_pkg::CHAR_BS;
            else if (pick < 14)
                c.ch = tccw_pkg::CHAR_TAB;
            else if (pick < 20)
                c.ch = tccw_pkg::CHAR_CR;
            else if (pick < 30)
                c.ch = tccw_pkg::CHAR_LF;
            else if (pick < 38)
                c.ch = tccw_pkg::CHAR_W'($urandom_range(0, 1) ? $urandom_range(0, 31)
                                                              : $urandom_range(128, 255));
            else
                c.ch = tccw_pkg::CHAR_W'($urandom_range(tccw_pkg::CHAR_SPACE,
                                                        tccw_pkg::CHAR_PRINT_HI));
        end
        else if (pick < 83)
        begin
            c.act = tccw_pkg::ACT_READ;
            cand  = CELLS;
            pos   = shadow_row * COLS + shadow_col - 1;
            if ($urandom_range(0, 7) == 0)
            begin
                cand = $urandom_range(CELLS, 2047);
            end
            else if ($urandom_range(0, 1) && pos >= 0 && cell_known[pos])
            begin
                cand = pos;
            end
            else
            begin
                for (int t = 0; t < 40 && cand == CELLS; t++)
                begin
                    pos = $urandom_range(0, CELLS - 1);
                    if (cell_known[pos])
                        cand = pos;
                end
            end
            c.idx = tccw_pkg::IDX_W'(cand);
        end
        else if (pick < 98 || clears_left == 0)
        begin
            c.act = tccw_pkg::ACT_SET;
        end
        else
        begin
            c.act = tccw_pkg::ACT_CLEAR;
            clears_left--;
        end
        queue_cmd(c.act, c.ch, c.idx, c.col, c.row);
    endtask

    // Wait until every command is sent and reported, then let background work end.
    // Sample on the falling edge so the clocked processes have settled.
    task automatic drain_and_settle();
        while (jobs_pending.size() != 0 || in_valid || reports_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both color registers back to back and mirror them in the shadow.
    task automatic write_colors(input logic [tccw_pkg::COLOR_W-1:0] bg,
                                input logic [tccw_pkg::COLOR_W-1:0] fg);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= tccw_pkg::REG_BACKGROUND;
        cfg_data  <= bg;
        @(posedge clk);
        cfg_index <= tccw_pkg::REG_FOREGROUND;
        cfg_data  <= fg;
        @(posedge clk);
        cfg_write <= 1'b0;
        shadow_bg = bg;
        shadow_fg = fg;
    endtask

    // Compare with four-state equality so unknown outputs are caught.
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Input driver: hold each command until accepted, then pause a random gap.
    always @(posedge clk or negedge rst_n)
    begin
        bit busy;
        console_job_t j;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            busy = in_valid;
            if (in_valid && in_ready)
            begin
                // The command is in; its report is now owed.
                reports_due.push_back(held_report);
                cmds_sent++;
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (jobs_pending.size() != 0)
                begin
                    j = jobs_pending.pop_front();
                    in_valid    <= 1'b1;
                    action      <= j.cmd.act;
                    char_code   <= j.cmd.ch;
                    cell_index  <= j.cmd.idx;
                    new_column  <= j.cmd.col;
                    new_row     <= j.cmd.row;
                    held_report = j.report;
                    send_gap    = pick_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: compare each report with the oldest owed one and stall
    // the output channel at random.
    always @(posedge clk or negedge rst_n)
    begin
        tccw_pkg::res_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                reports_seen++;
                if (reports_due.size() == 0)
                begin
                    $display("%0t: unexpected report: expected none, got col %0d row %0d",
                             $time, cursor_column, cursor_row);
                    fail_count++;
                end
                else
                begin
                    want = reports_due.pop_front();
                    check_field("cursor_column", 32'(want.col), 32'(cursor_column));
                    check_field("cursor_row", 32'(want.row), 32'(cursor_row));
                    check_field("cursor_offset", 32'(want.offset), 32'(cursor_offset));
                    check_field("cell_char", 32'(want.ch), 32'(cell_char));
                    check_field("cell_attr", 32'(want.attr), 32'(cell_attr));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (idle_enable && $urandom_range(0, 9) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Hang detection: count cycles in which neither channel moves.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles, %0d reports still owed",
                     $time, HANG_LIMIT, reports_due.size());
            $display("simulation failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        logic [tccw_pkg::COLOR_W-1:0] phase_bg [6];
        logic [tccw_pkg::COLOR_W-1:0] phase_fg [6];
        shadow_col  = 0;
        shadow_row  = 0;
        shadow_bg   = tccw_pkg::BACKGROUND_RESET;
        shadow_fg   = tccw_pkg::FOREGROUND_RESET;
        clears_left = 8;
        for (int i = 0; i < CELLS; i++)
        begin
            screen_shadow[i] = '0;
            cell_known[i]    = 1'b0;
        end
        // Color settings per random phase: the extremes first, then random.
        phase_bg = '{4'd15, 4'd0, 4'd15, 4'd0, 4'd0, 4'd0};
        phase_fg = '{4'd0, 4'd15, 4'd15, 4'd0, 4'd0, 4'd0};
        for (int p = 4; p < 6; p++)
        begin
            phase_bg[p] = tccw_pkg::COLOR_W'($urandom_range(0, 15));
            phase_fg[p] = tccw_pkg::COLOR_W'($urandom_range(0, 15));
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset colors.
        queue_cmd(tccw_pkg::ACT_READ, 8'h00, 11'd2047, 7'd0, 5'd0);   // index beyond screen
        queue_cmd(tccw_pkg::ACT_READ, 8'h00, 11'd2000, 7'd0, 5'd0);   // first index past end
        queue_cmd(tccw_pkg::ACT_PUT, 8'h41, 11'd0, 7'd0, 5'd0);
        queue_cmd(tccw_pkg::ACT_READ, 8'h00, 11'd0, 7'd0, 5'd0);
        queue_cmd(tccw_pkg::ACT_PUT, tccw_pkg::CHAR_BS, 11'd0, 7'd0, 5'd0);
        queue_cmd(tccw_pkg::ACT_PUT, tccw_pkg::CHAR_BS, 11'd0, 7'd0, 5'd0); // at origin
        queue_cmd(tccw_pkg::ACT_SET, 8'h00, 11'd0, 7'd127, 5'd31);    // saturate both
        queue_cmd(tccw_pkg::ACT_PUT, tccw_pkg::CHAR_PRINT_HI, 11'd0, 7'd0, 5'd0); // scroll
        queue_cmd(tccw_pkg::ACT_READ, 8'h00, 11'd1999, 7'd0, 5'd0);   // bottom row kept
        queue_cmd(tccw_pkg::ACT_READ, 8'h00, 11'd1919, 7'd0, 5'd0);   // moved up by scroll
        queue_cmd(tccw_pkg::ACT_PUT, tccw_pkg::CHAR_TAB, 11'd0, 7'd0, 5'd0);
        queue_cmd(tccw_pkg::ACT_SET, 8'h00, 11'd0, 7'd75, 5'd3);
        queue_cmd(tccw_pkg::ACT_PUT, tccw_pkg::CHAR_TAB, 11'd0, 7'd0, 5'd0); // past last col
        queue_cmd(tccw_pkg::ACT_PUT, tccw_pkg::CHAR_BS, 11'd0, 7'd0, 5'd0);  // previous row
        queue_cmd(tccw_pkg::ACT_PUT, tccw_pkg::CHAR_CR, 11'd0, 7'd0, 5'd0);
        queue_cmd(tccw_pkg::ACT_PUT, tccw_pkg::CHAR_LF, 11'd0, 7'd0, 5'd0);
        queue_cmd(tccw_pkg::ACT_PUT, 8'h00, 11'd0, 7'd0, 5'd0);
        queue_cmd(tccw_pkg::ACT_PUT, 8'h1F, 11'd0, 7'd0, 5'd0);
        queue_cmd(tccw_pkg::ACT_PUT, 8'h80, 11'd0, 7'd0, 5'd0);
        queue_cmd(tccw_pkg::ACT_PUT, 8'hFF, 11'd0, 7'd0, 5'd0);
        queue_cmd(tccw_pkg::ACT_CLEAR, 8'h00, 11'd0, 7'd0, 5'd0);
        queue_cmd(tccw_pkg::ACT_READ, 8'h00, 11'd1000, 7'd0, 5'd0);
        queue_cmd(tccw_pkg::ACT_SET, 8'h00, 11'd0, 7'd5, 5'd24);
        queue_cmd(tccw_pkg::ACT_PUT, tccw_pkg::CHAR_LF, 11'd0, 7'd0, 5'd0); // on last row
        queue_cmd(tccw_pkg::ACT_PUT, tccw_pkg::CHAR_SPACE, 11'd0, 7'd0, 5'd0);

        // Random phases; each starts from an idle block with fresh colors.
        for (int p = 0; p < 6; p++)
        begin
            drain_and_settle();
            write_colors(phase_bg[p], phase_fg[p]);
            idle_enable = (p != 2);
            for (int n = 0; n < 130; n++)
                queue_random_cmd();
        end

        drain_and_settle();
        $display("covered %0d commands and %0d reports: %0d scrolls, %0d clears, %0d cell reads",
                 cmds_sent, reports_seen, scroll_count, clear_count, reads_of_cells);
        $display("color settings: reset plus 6 phases including all-zero and all-ones");
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
